FILE: rtl/rlfs_pkg.sv
// Shared types and constants for the radio link failsafe steering block.
// Holds the register file layout, pipe and servo command codes, and result format.
// No dependencies.
`timescale 1ns / 1ps

package rlfs_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned REQ_DATA_WIDTH  = 16;
   localparam int unsigned REQ_USER_WIDTH  = 5;
   localparam int unsigned RSP_DATA_WIDTH  = 80;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DEADBAND_LOW    = 3'd0,
      REG_DEADBAND_HIGH   = 3'd1,
      REG_RIGHT_THRESHOLD = 3'd2,
      REG_LEFT_THRESHOLD  = 3'd3,
      REG_FAILSAFE_MISSES = 3'd4,
      REG_RELINK_MISSES   = 3'd5,
      REG_FAILSAFE_VALUE  = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      PIPE_DRIVE      = 3'd0,
      PIPE_VERTICAL   = 3'd1,
      PIPE_HORIZONTAL = 3'd2,
      PIPE_AUX        = 3'd3
   } pipe_type;

   typedef enum logic [1:0] {
      SERVO_NO_CHANGE = 2'd0,
      SERVO_ENABLE    = 2'd1,
      SERVO_DISABLE   = 2'd2
   } servo_cmd_type;

   localparam logic [11:0] PULSE_RIGHT  = 12'd2300;
   localparam logic [11:0] PULSE_LEFT   = 12'd550;
   localparam logic [11:0] PULSE_CENTRE = 12'd1450;
   localparam logic [7:0]  MISS_MAX     = 8'hFF;

   typedef struct packed {
      logic [15:0] deadband_low;
      logic [15:0] deadband_high;
      logic [15:0] right_threshold;
      logic [15:0] left_threshold;
      logic [7:0]  failsafe_misses;
      logic [7:0]  relink_misses;
      logic [15:0] failsafe_value;
   } cfg_type;

   typedef struct packed {
      logic       packet_present;
      logic [2:0] pipe;
      logic       read_ok;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } poll_type;

   // Packed from the top bit down so that the first field lands in the highest bits and the last in the lowest.
   typedef struct packed {
      logic [7:0]    miss_total;
      logic [7:0]    reset_total;
      logic          link_reset;
      logic [11:0]   servo_pulse;
      logic          pulse_update;
      servo_cmd_type servo_enable_cmd;
      logic [15:0]   drive_word;
      logic [15:0]   horizontal_value;
      logic [15:0]   vertical_value;
   } result_type;

endpackage

FILE: rtl/rlfs_csr.sv
// Configuration register file for the failsafe steering block.
// Depends on rlfs_pkg for the register layout and index codes.
`timescale 1ns / 1ps

module rlfs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rlfs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rlfs_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output rlfs_pkg::cfg_type                    cfg
);
   import rlfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DEADBAND_LOW:    cfg_in.deadband_low    = csr_data;
            REG_DEADBAND_HIGH:   cfg_in.deadband_high   = csr_data;
            REG_RIGHT_THRESHOLD: cfg_in.right_threshold = csr_data;
            REG_LEFT_THRESHOLD:  cfg_in.left_threshold  = csr_data;
            REG_FAILSAFE_MISSES: cfg_in.failsafe_misses = csr_data[7:0];
            REG_RELINK_MISSES:   cfg_in.relink_misses   = csr_data[7:0];
            REG_FAILSAFE_VALUE:  cfg_in.failsafe_value  = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_low    <= 16'd495;
         cfg_ff.deadband_high   <= 16'd515;
         cfg_ff.right_threshold <= 16'd525;
         cfg_ff.left_threshold  <= 16'd485;
         cfg_ff.failsafe_misses <= 8'd10;
         cfg_ff.relink_misses   <= 8'd20;
         cfg_ff.failsafe_value  <= 16'd505;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/rlfs_core.sv
// Link state and steering decision for one radio poll.
// Holds axis bytes, drive word, miss and reset counters and the last servo position.
// Depends on rlfs_pkg.
`timescale 1ns / 1ps

module rlfs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  rlfs_pkg::poll_type   poll,
   input  rlfs_pkg::cfg_type    cfg,
   output rlfs_pkg::result_type result
);
   import rlfs_pkg::*;

   logic [7:0]  vert_hi_ff, vert_lo_ff, hori_hi_ff, hori_lo_ff;
   logic [7:0]  vert_hi_in, vert_lo_in, hori_hi_in, hori_lo_in;
   logic [15:0] drive_ff, drive_in;
   logic [7:0]  miss_ff, miss_in;
   logic [7:0]  reset_cnt_ff, reset_cnt_in;
   logic [15:0] last_pos_ff, last_pos_in;

   logic [7:0]  miss_step;
   logic        link;
   logic        failsafe;
   logic [15:0] hori;
   logic        idle;

   always_comb begin
      vert_hi_in = vert_hi_ff;
      vert_lo_in = vert_lo_ff;
      hori_hi_in = hori_hi_ff;
      hori_lo_in = hori_lo_ff;
      drive_in   = drive_ff;
      miss_step  = miss_ff;

      if (poll.packet_present) begin
         unique case (poll.pipe)
            PIPE_DRIVE: begin
               drive_in  = {poll.second_byte, poll.first_byte};
               miss_step = 8'd0;
            end
            PIPE_VERTICAL: begin
               vert_hi_in = poll.read_ok ? poll.first_byte  : 8'd0;
               vert_lo_in = poll.read_ok ? poll.second_byte : 8'd0;
               miss_step  = 8'd0;
            end
            PIPE_HORIZONTAL: begin
               hori_hi_in = poll.read_ok ? poll.first_byte  : 8'd0;
               hori_lo_in = poll.read_ok ? poll.second_byte : 8'd0;
               miss_step  = 8'd0;
            end
            PIPE_AUX: miss_step = 8'd0;
            default:  miss_step = miss_ff;
         endcase
      end else if (miss_ff != MISS_MAX) begin
         miss_step = miss_ff + 8'd1;
      end

      link         = miss_step > cfg.relink_misses;
      miss_in      = link ? 8'd0 : miss_step;
      reset_cnt_in = reset_cnt_ff + {7'd0, link};
      failsafe     = miss_in > cfg.failsafe_misses;

      if (failsafe) begin
         vert_hi_in = cfg.failsafe_value[15:8];
         vert_lo_in = cfg.failsafe_value[7:0];
         hori_hi_in = cfg.failsafe_value[15:8];
         hori_lo_in = cfg.failsafe_value[7:0];
      end

      hori = {hori_hi_in, hori_lo_in};
      idle = (hori >= cfg.deadband_low) && (hori <= cfg.deadband_high);

      result.vertical_value   = {vert_hi_in, vert_lo_in};
      result.horizontal_value = hori;
      result.drive_word       = drive_in;
      result.servo_enable_cmd = SERVO_NO_CHANGE;
      result.pulse_update     = 1'b0;
      result.servo_pulse      = 12'd0;
      result.link_reset       = link;
      result.reset_total      = reset_cnt_in;
      result.miss_total       = miss_in;
      last_pos_in             = last_pos_ff;

      if (!idle) begin
         result.servo_enable_cmd = SERVO_ENABLE;
         if (hori > cfg.right_threshold) begin
            result.pulse_update = 1'b1;
            result.servo_pulse  = PULSE_RIGHT;
         end else if (hori < cfg.left_threshold) begin
            result.pulse_update = 1'b1;
            result.servo_pulse  = PULSE_LEFT;
         end
         last_pos_in = hori;
      end else if (last_pos_ff != {4'd0, PULSE_CENTRE}) begin
         result.servo_enable_cmd = SERVO_DISABLE;
         result.pulse_update     = 1'b1;
         result.servo_pulse      = PULSE_CENTRE;
         last_pos_in             = {4'd0, PULSE_CENTRE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vert_hi_ff   <= 8'd0;
         vert_lo_ff   <= 8'd0;
         hori_hi_ff   <= 8'd0;
         hori_lo_ff   <= 8'd0;
         drive_ff     <= 16'd0;
         miss_ff      <= 8'd0;
         reset_cnt_ff <= 8'd0;
         last_pos_ff  <= 16'd0;
      end else if (advance) begin
         vert_hi_ff   <= vert_hi_in;
         vert_lo_ff   <= vert_lo_in;
         hori_hi_ff   <= hori_hi_in;
         hori_lo_ff   <= hori_lo_in;
         drive_ff     <= drive_in;
         miss_ff      <= miss_in;
         reset_cnt_ff <= reset_cnt_in;
         last_pos_ff  <= last_pos_in;
      end
   end

endmodule

FILE: rtl/rc_link_failsafe_steering_unit.sv
// Top level of the radio link failsafe steering block.
// Instantiates rlfs_csr and rlfs_core; depends on rlfs_pkg.
//
//   Channel  Direction  Ports                              Moves
//   req      in         req_tvalid req_tready req_tdata    one radio poll
//                       req_tuser
//   rsp      out        rsp_tvalid rsp_tready rsp_tdata    one result per poll
//   csr      in         csr_valid csr_ready csr_index      one register write
//                       csr_data
//
// A poll is captured in an input register and evaluated into the result register when
// that register is free, and the result is offered on rsp from there; one poll per cycle
// is sustained while rsp_tready is high, as rlfs_core updates its state for each poll.
// Reset is synchronous and returns the register file to its defaults and all link state to zero.
// A stalled rsp side holds the result register and the input register keeps one more poll
// before req_tready falls. The csr port is always ready.
`timescale 1ns / 1ps

module rc_link_failsafe_steering_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // first_byte [7:0], second_byte [15:8]
   input  logic [rlfs_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // packet_present [0], pipe [3:1], read_ok [4]
   input  logic [rlfs_pkg::REQ_USER_WIDTH-1:0]  req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // vertical_value [15:0], horizontal_value [31:16], drive_word [47:32],
   // servo_enable_cmd [49:48], pulse_update [50], servo_pulse [62:51],
   // link_reset [63], reset_total [71:64], miss_total [79:72]
   output logic [rlfs_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rlfs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rlfs_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import rlfs_pkg::*;

   cfg_type    cfg;
   poll_type   poll_ff;
   logic       poll_valid_ff;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance    = poll_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !poll_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff;

   rlfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rlfs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .poll    (poll_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            poll_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         poll_ff.packet_present <= req_tuser[0];
         poll_ff.pipe           <= req_tuser[3:1];
         poll_ff.read_ok        <= req_tuser[4];
         poll_ff.first_byte     <= req_tdata[7:0];
         poll_ff.second_byte    <= req_tdata[15:8];
      end
      if (advance) begin
         result_ff <= result;
      end
   end

endmodule
